// ===== src/cs_pkg.sv =====
// Package: shared constants and types for the cosine similarity stream.
package cs_pkg;

  localparam int MAX_LEN = 1024;
  localparam int ELEM_W  = 16;
  localparam int FRAC_W  = 15;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int SQR_W   = PROD_W - 1;
  localparam int NORM_W  = $clog2(MAX_LEN) + 2 * FRAC_W + 1;
  localparam int DOT_W   = NORM_W + 1;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int SQ_W    = 2 * NORM_W;
  localparam int ROOT_W  = 16;
  localparam int BIT_W   = $clog2(ROOT_W);
  localparam int TRY_W   = SQ_W + 2 * ROOT_W;
  localparam int MCNT_W  = $clog2(NORM_W);
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic signed [ELEM_W-1:0] SIM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

  typedef struct packed {
    logic signed [DOT_W-1:0] dot;
    logic [NORM_W-1:0]       norm_a;
    logic [NORM_W-1:0]       norm_b;
    logic                    too_long;
  } cs_job_t;

  typedef struct packed {
    logic              not_empty;
    logic [QCNT_W-1:0] level;
  } cs_qstat_t;

endpackage

// ===== src/cs_if.sv =====
// Interfaces: element pair request channel and result request channel.
interface cs_in_if;
  import cs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ELEM_W-1:0] elem_a;
  logic signed [ELEM_W-1:0] elem_b;
  logic                    last;

  modport source (output valid, output elem_a, output elem_b, output last, input ready);
  modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface cs_out_if;
  import cs_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [ELEM_W-1:0] similarity;
  logic                    degenerate;
  logic                    too_long;

  modport source (output valid, output similarity, output degenerate, output too_long,
                  input ready);
  modport sink   (input valid, input similarity, input degenerate, input too_long,
                  output ready);
endinterface

// ===== src/cs_front.sv =====
// Front end: accepts element pairs, multiplies, accumulates and queues finished vectors.
module cs_front (
  input  logic             clk,
  input  logic             rst_n,
  cs_in_if.sink            in_chan,
  input  cs_pkg::cs_qstat_t qstat,
  output logic             push,
  output cs_pkg::cs_job_t  job
);
  import cs_pkg::*;

  logic                     s1_valid_r;
  logic                     s1_last_r;
  logic signed [PROD_W-1:0] s1_ab_r;
  logic [SQR_W-1:0]         s1_aa_r;
  logic [SQR_W-1:0]         s1_bb_r;

  logic signed [DOT_W-1:0]  dot_r, dot_nxt;
  logic [NORM_W-1:0]        na_r, na_nxt;
  logic [NORM_W-1:0]        nb_r, nb_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     ovf_r, ovf_nxt;

  logic signed [PROD_W-1:0] ab_w, aa_w, bb_w;
  logic [QCNT_W:0]          room_need;
  logic                     full;
  logic signed [DOT_W-1:0]  dot_sum;
  logic [NORM_W-1:0]        na_sum, nb_sum;
  logic                     accept;

  assign room_need = {1'b0, qstat.level} + (QCNT_W+1)'(s1_valid_r && s1_last_r);
  assign in_chan.ready = room_need < (QCNT_W+1)'(QDEPTH);
  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    ab_w = in_chan.elem_a * in_chan.elem_b;
    aa_w = in_chan.elem_a * in_chan.elem_a;
    bb_w = in_chan.elem_b * in_chan.elem_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
    if (accept) begin
      s1_last_r <= in_chan.last;
      s1_ab_r   <= ab_w;
      s1_aa_r   <= aa_w[SQR_W-1:0];
      s1_bb_r   <= bb_w[SQR_W-1:0];
    end
  end

  // Pairs past the length limit only mark the vector.
  assign full    = (cnt_r == CNT_W'(MAX_LEN));
  assign dot_sum = full ? dot_r : dot_r + DOT_W'(s1_ab_r);
  assign na_sum  = full ? na_r : na_r + NORM_W'(s1_aa_r);
  assign nb_sum  = full ? nb_r : nb_r + NORM_W'(s1_bb_r);

  always_comb begin
    dot_nxt      = dot_r;
    na_nxt       = na_r;
    nb_nxt       = nb_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    push         = 1'b0;
    job.dot      = dot_sum;
    job.norm_a   = na_sum;
    job.norm_b   = nb_sum;
    job.too_long = ovf_r || full;
    if (s1_valid_r) begin
      if (s1_last_r) begin
        push    = 1'b1;
        dot_nxt = '0;
        na_nxt  = '0;
        nb_nxt  = '0;
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        dot_nxt = dot_sum;
        na_nxt  = na_sum;
        nb_nxt  = nb_sum;
        ovf_nxt = ovf_r || full;
        if (!full) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      na_r  <= '0;
      nb_r  <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      dot_r <= dot_nxt;
      na_r  <= na_nxt;
      nb_r  <= nb_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_LEN))
    else $error("pair count past limit");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> full)
    else $error("overflow flag without full count");

  a_push_last: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> $past(accept && in_chan.last))
    else $error("vector queued without a last request");

endmodule

// ===== src/cs_queue.sv =====
// Queue of finished vector accumulations between front and back end.
module cs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cs_pkg::cs_job_t   push_job,
  input  logic              pop,
  output cs_pkg::cs_job_t   head_job,
  output cs_pkg::cs_qstat_t qstat
);
  import cs_pkg::*;

  cs_job_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    r = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    return r;
  endfunction

  assign head_job        = mem_r[rd_ptr_r];
  assign qstat.not_empty = (cnt_r != '0);
  assign qstat.level     = cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r < QCNT_W'(QDEPTH))
    else $error("queue overrun");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue underrun");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue level out of range");

endmodule

// ===== src/cs_core.sv =====
// Back end: serial squaring, bitwise root search and result register.
module cs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  cs_pkg::cs_qstat_t qstat,
  input  cs_pkg::cs_job_t   head_job,
  output logic              pop,
  cs_out_if.source          out_chan
);
  import cs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_TRY  = 5'b00100,
    ST_CMP  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic              neg_r, neg_nxt;
  logic              tl_r, tl_nxt;
  logic              dg_r, dg_nxt;
  logic [SQ_W-1:0]   na_sh_r, na_sh_nxt;
  logic [NORM_W-1:0] nb_mul_r, nb_mul_nxt;
  logic [SQ_W-1:0]   mag_sh_r, mag_sh_nxt;
  logic [NORM_W-1:0] mag_mul_r, mag_mul_nxt;
  logic [SQ_W-1:0]   p_r, p_nxt;
  logic [SQ_W-1:0]   m_r, m_nxt;
  logic [MCNT_W-1:0] mcnt_r, mcnt_nxt;
  logic [TRY_W-1:0]  t_r, t_nxt;
  logic [TRY_W-1:0]  ush_r, ush_nxt;
  logic [TRY_W-1:0]  pbb_r, pbb_nxt;
  logic [TRY_W-1:0]  d_r, d_nxt;
  logic [TRY_W-1:0]  cand_r, cand_nxt;
  logic [ROOT_W-1:0] s_r, s_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;

  logic                     ovalid_r, ovalid_nxt;
  logic signed [ELEM_W-1:0] sim_r, sim_nxt;
  logic                     odg_r, odg_nxt;
  logic                     otl_r, otl_nxt;

  logic                     head_neg;
  logic [NORM_W-1:0]        head_mag;
  logic                     head_dg;
  logic                     out_free;
  logic signed [ELEM_W-1:0] sim_val;

  assign head_neg = head_job.dot < 0;
  assign head_mag = head_neg ? NORM_W'(-head_job.dot) : NORM_W'(head_job.dot);
  assign head_dg  = (head_job.norm_a == '0) || (head_job.norm_b == '0);
  assign out_free = !ovalid_r || out_chan.ready;

  always_comb begin
    if (neg_r) begin
      sim_val = ELEM_W'(-s_r);
    end else if (s_r[ROOT_W-1]) begin
      sim_val = SIM_MAX;
    end else begin
      sim_val = ELEM_W'(s_r);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    neg_nxt     = neg_r;
    tl_nxt      = tl_r;
    dg_nxt      = dg_r;
    na_sh_nxt   = na_sh_r;
    nb_mul_nxt  = nb_mul_r;
    mag_sh_nxt  = mag_sh_r;
    mag_mul_nxt = mag_mul_r;
    p_nxt       = p_r;
    m_nxt       = m_r;
    mcnt_nxt    = mcnt_r;
    t_nxt       = t_r;
    ush_nxt     = ush_r;
    pbb_nxt     = pbb_r;
    d_nxt       = d_r;
    cand_nxt    = cand_r;
    s_nxt       = s_r;
    bit_nxt     = bit_r;
    ovalid_nxt  = ovalid_r && !out_chan.ready;
    sim_nxt     = sim_r;
    odg_nxt     = odg_r;
    otl_nxt     = otl_r;
    pop         = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (qstat.not_empty) begin
          pop         = 1'b1;
          tl_nxt      = head_job.too_long;
          dg_nxt      = !head_job.too_long && head_dg;
          neg_nxt     = head_neg && !head_job.too_long && !head_dg;
          na_sh_nxt   = SQ_W'(head_job.norm_a);
          nb_mul_nxt  = head_job.norm_b;
          mag_sh_nxt  = SQ_W'(head_mag);
          mag_mul_nxt = head_mag;
          p_nxt       = '0;
          m_nxt       = '0;
          s_nxt       = '0;
          mcnt_nxt    = MCNT_W'(NORM_W - 1);
          if (head_job.too_long || head_dg) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // One bit of each product per cycle: norm_a*norm_b and |dot|^2.
        p_nxt       = p_r + (nb_mul_r[0] ? na_sh_r : '0);
        m_nxt       = m_r + (mag_mul_r[0] ? mag_sh_r : '0);
        na_sh_nxt   = na_sh_r << 1;
        nb_mul_nxt  = nb_mul_r >> 1;
        mag_sh_nxt  = mag_sh_r << 1;
        mag_mul_nxt = mag_mul_r >> 1;
        mcnt_nxt    = mcnt_r - MCNT_W'(1);
        if (mcnt_r == '0) begin
          t_nxt     = '0;
          ush_nxt   = '0;
          pbb_nxt   = TRY_W'(p_nxt) << (2 * (ROOT_W - 1));
          d_nxt     = TRY_W'(m_nxt) << (2 * FRAC_W);
          bit_nxt   = BIT_W'(ROOT_W - 1);
          state_nxt = ST_TRY;
        end
      end
      ST_TRY: begin
        // (s + 2^b)^2 * P = s^2*P + s*P*2^(b+1) + P*2^(2b)
        cand_nxt  = t_r + ush_r + pbb_r;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (cand_r <= d_r) begin
          t_nxt   = cand_r;
          s_nxt   = s_r | (ROOT_W'(1) << bit_r);
          ush_nxt = (ush_r >> 1) + pbb_r;
        end else begin
          ush_nxt = ush_r >> 1;
        end
        pbb_nxt = pbb_r >> 2;
        bit_nxt = bit_r - BIT_W'(1);
        if (bit_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_TRY;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          sim_nxt    = sim_val;
          odg_nxt    = dg_r;
          otl_nxt    = tl_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
    neg_r     <= neg_nxt;
    tl_r      <= tl_nxt;
    dg_r      <= dg_nxt;
    na_sh_r   <= na_sh_nxt;
    nb_mul_r  <= nb_mul_nxt;
    mag_sh_r  <= mag_sh_nxt;
    mag_mul_r <= mag_mul_nxt;
    p_r       <= p_nxt;
    m_r       <= m_nxt;
    mcnt_r    <= mcnt_nxt;
    t_r       <= t_nxt;
    ush_r     <= ush_nxt;
    pbb_r     <= pbb_nxt;
    d_r       <= d_nxt;
    cand_r    <= cand_nxt;
    s_r       <= s_nxt;
    bit_r     <= bit_nxt;
    sim_r     <= sim_nxt;
    odg_r     <= odg_nxt;
    otl_r     <= otl_nxt;
  end

  assign out_chan.valid      = ovalid_r;
  assign out_chan.similarity = sim_r;
  assign out_chan.degenerate = odg_r;
  assign out_chan.too_long   = otl_r;

  a_root_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (t_r <= d_r))
    else $error("accepted root trial exceeds target");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> !(s_r[ROOT_W-1] && (s_r[ROOT_W-2:0] != '0)))
    else $error("root magnitude above unity");

  a_flags_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && (otl_r || odg_r)) |-> (sim_r == '0) && !(otl_r && odg_r))
    else $error("flagged result not zero");

endmodule

// ===== src/cosine_similarity_stream.sv =====
// Top level: cosine similarity of two streamed Q1.15 vectors.
// Element pairs are taken one per cycle while the vector queue has room; each pair
// is multiplied in one stage and accumulated in the next. On the pair marked last
// the sums go into a two-entry queue. The back end then runs a bit-serial pass
// that forms norm_a*norm_b and dot^2, then a 16-step bitwise root search that
// settles one result bit per step. The front keeps streaming the next vector
// meanwhile, as long as the queue has room. Vectors longer than MAX_LEN report
// too_long; a zero norm reports degenerate.
module cosine_similarity_stream (
  input  logic      clk,
  input  logic      rst_n,
  cs_in_if.sink     in_chan,
  cs_out_if.source  out_chan
);
  import cs_pkg::*;

  cs_job_t   push_job;
  cs_job_t   head_job;
  cs_qstat_t qstat;
  logic      push;
  logic      pop;

  cs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .qstat   (qstat),
    .push    (push),
    .job     (push_job)
  );

  cs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .qstat    (qstat)
  );

  cs_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .qstat    (qstat),
    .head_job (head_job),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule
